@@ hdl/lir_pkg.sv @@
// Shared constants and types for the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 21;
  localparam int FRAC_BITS = 16;
  localparam int PHASE_W   = FRAC_BITS + 5;
  localparam int CMP_W     = (STEP_W > PHASE_W) ? STEP_W : PHASE_W;
  localparam int CNT_W     = $clog2(FRAC_BITS + 1);
  localparam int ACC_W     = SAMPLE_W + 2;

  localparam logic [PHASE_W-1:0] ONE      = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] TWO      = ONE << 1;
  localparam logic [PHASE_W-1:0] STEP_MIN = ONE >> 5;
  localparam logic [PHASE_W-1:0] STEP_MAX = ONE << 4;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(64'(1) << FRAC_BITS);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

endpackage

@@ hdl/lir_if.sv @@
// Request channel interfaces for source samples and resampled results.
interface lir_in_if;
  logic              valid;
  logic              ready;
  lir_pkg::sample_t  sample;
  logic              final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink (input valid, input sample, input final_sample, output ready);
endinterface

interface lir_out_if;
  logic              valid;
  logic              ready;
  lir_pkg::sample_t  out_sample;
  logic              run_last;
  logic              stream_done;

  modport source (output valid, output out_sample, output run_last, output stream_done,
                  input ready);
  modport sink (input valid, input out_sample, input run_last, input stream_done,
                output ready);
endinterface

@@ hdl/lir_mac.sv @@
// Bit-serial interpolator that forms s0 + (s1 - s0) * frac, truncated toward zero.
module lir_mac (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lir_pkg::sample_t   s0,
  input  lir_pkg::sample_t   s1,
  input  lir_pkg::frac_t     frac,
  output lir_pkg::mac_stat_t stat,
  output lir_pkg::sample_t   result
);

  logic                                busy;
  logic                                done;
  logic [lir_pkg::CNT_W-1:0]           cnt;
  logic signed [lir_pkg::SAMPLE_W:0]   diff;
  lir_pkg::frac_t                      mcand;
  lir_pkg::sample_t                    s0_reg;
  logic signed [lir_pkg::ACC_W-1:0]    hi;
  lir_pkg::frac_t                      lo;
  logic signed [lir_pkg::ACC_W-1:0]    sum;
  logic signed [lir_pkg::ACC_W-1:0]    quot;
  logic signed [lir_pkg::ACC_W-1:0]    res;

  always_comb begin
    sum  = hi + (mcand[0] ? lir_pkg::ACC_W'(diff) : '0);
    quot = lir_pkg::ACC_W'(s0_reg) + hi;
    res  = quot + lir_pkg::ACC_W'(quot[lir_pkg::ACC_W-1] && (|lo));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= lir_pkg::CNT_W'(lir_pkg::FRAC_BITS);
        diff   <= (lir_pkg::SAMPLE_W+1)'(s1) - (lir_pkg::SAMPLE_W+1)'(s0);
        mcand  <= frac;
        s0_reg <= s0;
        hi     <= '0;
        lo     <= '0;
      end else if (busy) begin
        if (cnt != '0) begin
          hi    <= sum >>> 1;
          lo    <= {sum[0], lo[lir_pkg::FRAC_BITS-1:1]};
          mcand <= mcand >> 1;
          cnt   <= cnt - 1'b1;
        end else begin
          result <= res[lir_pkg::SAMPLE_W-1:0];
          done   <= 1'b1;
          busy   <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ hdl/linear_interp_resampler.sv @@
// Top level of the linear interpolation sample-rate converter.
//  Channel   Direction  Carries
//  src       in         sample, final_sample
//  dst       out        out_sample, run_last, stream_done
//  cfg_wr_*  in         phase_step, written whenever cfg_wr_en is high
// The first sample of a stream gives no result unless it is also the final sample.
// Each interpolated result is formed by the bit-serial multiplier that consumes one
// phase bit per cycle; end-of-stream results repeat the held sample without it.
// A new request is taken only when the previous one has produced all its results.
// A held result in the output register stalls the next result and, with it, the input.
// Reset is synchronous and returns the block to the start of a new stream.
module linear_interp_resampler (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  lir_pkg::step_t       cfg_wr_data,
  lir_in_if.sink               src,
  lir_out_if.source            dst
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK_I,
    MUL,
    EMIT_I,
    FLUSH
  } state_t;

  state_t             state;
  lir_pkg::step_t     step_reg;
  lir_pkg::phase_t    step_eff;
  lir_pkg::phase_t    phase;
  lir_pkg::phase_t    phase_next;
  lir_pkg::sample_t   held;
  lir_pkg::sample_t   cur_sample;
  logic               cur_final;
  logic               have_held;
  logic               out_valid;
  lir_pkg::sample_t   out_sample;
  logic               run_last;
  logic               stream_done;
  logic               out_free;
  logic               out_load;
  logic               mac_start;
  lir_pkg::mac_stat_t mac_stat;
  lir_pkg::sample_t   mac_result;

  always_comb begin
    if (lir_pkg::CMP_W'(step_reg) < lir_pkg::CMP_W'(lir_pkg::STEP_MIN)) begin
      step_eff = lir_pkg::STEP_MIN;
    end else if (lir_pkg::CMP_W'(step_reg) > lir_pkg::CMP_W'(lir_pkg::STEP_MAX)) begin
      step_eff = lir_pkg::STEP_MAX;
    end else begin
      step_eff = lir_pkg::PHASE_W'(step_reg);
    end
  end

  assign phase_next = phase + step_eff;
  assign out_free   = !out_valid || dst.ready;
  assign out_load   = ((state == EMIT_I) || ((state == FLUSH) && (phase < lir_pkg::ONE))) &&
                      out_free;
  assign mac_start  = (state == CHECK_I) && (phase < lir_pkg::ONE);

  lir_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .s0     (held),
    .s1     (cur_sample),
    .frac   (phase[lir_pkg::FRAC_BITS-1:0]),
    .stat   (mac_stat),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step_reg  <= lir_pkg::STEP_RESET;
      phase     <= '0;
      held      <= '0;
      have_held <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        step_reg <= cfg_wr_data;
      end
      if (out_valid && dst.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (src.valid) begin
            if (have_held) begin
              cur_sample <= src.sample;
              cur_final  <= src.final_sample;
              state      <= CHECK_I;
            end else begin
              held      <= src.sample;
              have_held <= 1'b1;
              phase     <= '0;
              state     <= src.final_sample ? FLUSH : IDLE;
            end
          end
        end
        CHECK_I: begin
          if (phase < lir_pkg::ONE) begin
            state <= MUL;
          end else begin
            phase <= phase - lir_pkg::ONE;
            held  <= cur_sample;
            state <= cur_final ? FLUSH : IDLE;
          end
        end
        MUL: begin
          if (mac_stat.done) begin
            state <= EMIT_I;
          end
        end
        EMIT_I: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_sample  <= mac_result;
            stream_done <= cur_final;
            run_last    <= (phase_next >= lir_pkg::ONE) &&
                           (!cur_final || (phase_next >= lir_pkg::TWO));
            phase       <= phase_next;
            state       <= CHECK_I;
          end
        end
        FLUSH: begin
          if (phase >= lir_pkg::ONE) begin
            held      <= '0;
            phase     <= '0;
            have_held <= 1'b0;
            state     <= IDLE;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            out_sample  <= held;
            stream_done <= 1'b1;
            run_last    <= phase_next >= lir_pkg::ONE;
            phase       <= phase_next;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign src.ready       = (state == IDLE);
  assign dst.valid       = out_valid;
  assign dst.out_sample  = out_sample;
  assign dst.run_last    = run_last;
  assign dst.stream_done = stream_done;

  a_ready_mac_idle: assert property (@(posedge clk) disable iff (rst)
    src.ready |-> !mac_stat.busy)
    else $error("input taken while the multiplier is busy");

  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mac_stat.done |-> (state == MUL))
    else $error("multiplier finished outside its wait state");

  a_idle_phase_bound: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (phase <= lir_pkg::STEP_MAX))
    else $error("phase out of range between requests");

  a_fresh_phase: assert property (@(posedge clk) disable iff (rst)
    ((state == IDLE) && !have_held) |-> (phase == '0))
    else $error("phase not cleared at stream start");

endmodule

@@ bench/linear_interp_resampler_tb.sv @@
// Self-checking testbench for the linear interpolation resampler.
`timescale 1ns / 100ps

module linear_interp_resampler_tb;

  localparam int IDLE_PCT     = 17;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 30;

  typedef struct {
    lir_pkg::sample_t out_sample;
    bit               run_last;
    bit               stream_done;
  } resample_result_t;

  logic           clk = 1'b0;
  logic           rst;
  logic           cfg_wr_en;
  lir_pkg::step_t cfg_wr_data;

  lir_in_if  src_if ();
  lir_out_if dst_if ();

  linear_interp_resampler dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .src         (src_if),
    .dst         (dst_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  resample_result_t pending_results[$];

  lir_pkg::step_t   step_copy;
  lir_pkg::sample_t held_copy;
  int unsigned      phase_copy;
  bit               holding_copy;

  bit no_idle;
  bit hold_req;
  int error_count;
  int requests_sent;
  int streams_sent;
  int results_checked;
  int settings_used;
  int quiet_cycles;

  function automatic lir_pkg::sample_t interp_sample(lir_pkg::sample_t s0,
                                                     lir_pkg::sample_t s1, int unsigned ph);
    longint scale;
    longint num;
    scale = longint'(1) << lir_pkg::FRAC_BITS;
    num = longint'(s0) * scale + (longint'(s1) - longint'(s0)) * longint'(ph);
    return lir_pkg::sample_t'(num / scale);
  endfunction

  function automatic void push_result(lir_pkg::sample_t v, bit fin);
    resample_result_t r;
    r.out_sample  = v;
    r.run_last    = 1'b0;
    r.stream_done = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_resample(lir_pkg::sample_t s1, bit fin);
    int unsigned eff_step;
    int n;
    eff_step = step_copy;
    if (eff_step < lir_pkg::STEP_MIN) eff_step = lir_pkg::STEP_MIN;
    if (eff_step > lir_pkg::STEP_MAX) eff_step = lir_pkg::STEP_MAX;
    n = 0;
    if (holding_copy) begin
      while (phase_copy < lir_pkg::ONE) begin
        push_result(interp_sample(held_copy, s1, phase_copy), fin);
        n++;
        phase_copy += eff_step;
      end
      phase_copy -= lir_pkg::ONE;
    end else begin
      phase_copy = 0;
    end
    held_copy    = s1;
    holding_copy = 1'b1;
    if (fin) begin
      while (phase_copy < lir_pkg::ONE) begin
        push_result(held_copy, fin);
        n++;
        phase_copy += eff_step;
      end
      held_copy    = '0;
      phase_copy   = 0;
      holding_copy = 1'b0;
    end
    if (n > 0) pending_results[pending_results.size() - 1].run_last = 1'b1;
  endfunction

  task automatic send_request(lir_pkg::sample_t s, bit fin);
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      src_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    src_if.valid        <= 1'b1;
    src_if.sample       <= s;
    src_if.final_sample <= fin;
    do @(posedge clk); while (!src_if.ready);
    predict_resample(s, fin);
    requests_sent++;
    if (fin) streams_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    src_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(lir_pkg::step_t v);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    step_copy = v;
    settings_used++;
  endtask

  function automatic lir_pkg::sample_t pick_sample();
    case ($urandom_range(19))
      0: return lir_pkg::sample_t'(16'h8000);
      1: return lir_pkg::sample_t'(16'h7fff);
      2: return lir_pkg::sample_t'(16'h0000);
      3: return lir_pkg::sample_t'(16'hffff);
      default: return lir_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic send_stream(int len);
    for (int i = 0; i < len; i++) send_request(pick_sample(), i == len - 1);
  endtask

  task automatic test_stream_edges();
    send_request(16'sd5, 1'b1);
    send_request(16'sd100, 1'b0);
    send_request(-16'sd32768, 1'b0);
    send_request(16'sd32767, 1'b1);
  endtask

  task automatic test_upsample_extremes();
    write_step(lir_pkg::step_t'(16384));
    send_request(-16'sd32768, 1'b0);
    send_request(16'sd32767, 1'b0);
    send_request(-16'sd32768, 1'b1);
  endtask

  task automatic test_downsample();
    write_step(lir_pkg::step_t'(229376));
    send_request(16'sd1000, 1'b0);
    send_request(-16'sd2000, 1'b0);
    send_request(16'sd32767, 1'b0);
    send_request(-16'sd32768, 1'b0);
    send_request(16'sd7, 1'b0);
    send_request(-16'sd1, 1'b1);
  endtask

  task automatic test_step_saturation();
    write_step(lir_pkg::step_t'(0));
    send_request(16'sd32767, 1'b0);
    send_request(-16'sd32768, 1'b1);
    write_step(lir_pkg::step_t'(21'h1fffff));
    send_request(16'sd12345, 1'b0);
    send_request(-16'sd12345, 1'b0);
    send_request(16'sd32767, 1'b1);
  endtask

  task automatic test_random_streams();
    lir_pkg::step_t steps[6];
    int target;
    steps[0] = lir_pkg::step_t'(2048);
    steps[1] = lir_pkg::step_t'(1048576);
    steps[2] = lir_pkg::step_t'(2047);
    steps[3] = lir_pkg::step_t'(1048577);
    steps[4] = lir_pkg::step_t'($urandom_range(131072, 8192));
    steps[5] = lir_pkg::step_t'($urandom_range(98304, 20000));
    for (int p = 0; p < 6; p++) begin
      write_step(steps[p]);
      no_idle = (p == 5);
      target = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) begin
        if ($urandom_range(4) == 0) send_stream(1);
        else send_stream($urandom_range(10, 2));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    write_step(lir_pkg::step_t'(8192));
    hold_req = 1'b1;
    send_stream(8);
    while (hold_req) @(posedge clk);
  endtask

  // Each result is checked at the edge that accepts it.
  always @(posedge clk) begin : result_check
    resample_result_t want;
    if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (dst_if.valid && dst_if.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, got out_sample %0d", $time,
                 dst_if.out_sample);
      end else begin
        want = pending_results.pop_front();
        if (dst_if.out_sample !== want.out_sample) begin
          error_count++;
          $display("%0t: out_sample expected %0d got %0d", $time, want.out_sample,
                   dst_if.out_sample);
        end
        if (dst_if.run_last !== want.run_last) begin
          error_count++;
          $display("%0t: run_last expected %0b got %0b", $time, want.run_last,
                   dst_if.run_last);
        end
        if (dst_if.stream_done !== want.stream_done) begin
          error_count++;
          $display("%0t: stream_done expected %0b got %0b", $time, want.stream_done,
                   dst_if.stream_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
      $display("linear_interp_resampler verification failed");
      $finish;
    end
  end

  // The receiver idles at random, and holds off for a long stretch on demand.
  initial begin : result_sink
    dst_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        dst_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      dst_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    src_if.valid = 1'b0;
    src_if.sample = '0;
    src_if.final_sample = 1'b0;
    step_copy = lir_pkg::STEP_RESET;
    held_copy = '0;
    phase_copy = 0;
    holding_copy = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_stream_edges();
    test_upsample_extremes();
    test_downsample();
    test_step_saturation();
    test_random_streams();
    test_output_backpressure();
    wait_idle();

    $display("Sent %0d requests in %0d streams over %0d step settings.", requests_sent,
             streams_sent, settings_used + 1);
    $display("Checked %0d results, including saturated steps and a long output stall.",
             results_checked);
    if (error_count == 0) begin
      $display("linear_interp_resampler verification clean");
    end else begin
      $display("linear_interp_resampler verification failed");
    end
    $finish;
  end

endmodule
